// ===== hdl/jsesc_pkg.sv =====
// Shared types, character constants and helper functions for the JSON string escaper.
// Used by jsesc_decode, jsesc_emit and json_string_ascii_escaper_top. No dependencies.
package jsesc_pkg;

  localparam logic [2:0] MK_NONE = 3'd0;
  localparam logic [2:0] MK_ONE  = 3'd1;
  localparam logic [2:0] MK_TWO  = 3'd2;
  localparam logic [2:0] MK_U16  = 3'd3;
  localparam logic [2:0] MK_PAIR = 3'd4;

  localparam logic [6:0] CH_QUOTE = 7'h22;
  localparam logic [6:0] CH_BSL   = 7'h5C;
  localparam logic [6:0] CH_U     = 7'h75;

  localparam logic [15:0] REPL_CHAR = 16'hFFFD;

  // Everything one word expands to, in output order.
  typedef struct packed {
    logic        q_open;
    logic [1:0]  pre_n;
    logic [2:0]  kind;
    logic [6:0]  ch;
    logic [15:0] v0;
    logic [15:0] v1;
    logic [1:0]  post_n;
    logic        q_close;
  } jsesc_plan_t;

  function automatic logic [6:0] hex_char(input logic [3:0] n);
    logic [6:0] c;
    if (n < 4'd10) begin
      c = 7'h30 + {3'b000, n};
    end else begin
      c = 7'h57 + {3'b000, n};
    end
    return c;
  endfunction

  // Character at position i of the six-character \uxxxx form of v.
  function automatic logic [6:0] u16_char(input logic [15:0] v, input logic [2:0] i);
    logic [6:0] c;
    case (i)
      3'd0: c = CH_BSL;
      3'd1: c = CH_U;
      3'd2: c = hex_char(v[15:12]);
      3'd3: c = hex_char(v[11:8]);
      3'd4: c = hex_char(v[7:4]);
      default: c = hex_char(v[3:0]);
    endcase
    return c;
  endfunction

endpackage

// ===== hdl/jsesc_decode.sv =====
// Input decode for the JSON string escaper: UTF-8 sequence state and the per-word plan.
// Depends on jsesc_pkg.
module jsesc_decode (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic [7:0]         data_byte,
  input  logic               first_byte,
  input  logic               last_byte,
  input  logic               is_empty,
  output jsesc_pkg::jsesc_plan_t plan
);
  import jsesc_pkg::*;

  logic [7:0] held_bytes [3];
  logic [1:0] held_count;
  logic [1:0] held_count_next;
  logic [2:0] needed_length;
  logic [2:0] needed_length_next;
  logic       wr_en;
  logic [1:0] wr_idx;

  always_comb begin
    logic [1:0]  hc0;
    logic [2:0]  nl0;
    logic        do_start;
    logic [20:0] cp;
    logic [20:0] r;
    plan = '0;
    plan.kind = MK_NONE;
    wr_en = 1'b0;
    wr_idx = 2'd0;
    do_start = 1'b0;
    cp = '0;
    r = '0;
    hc0 = first_byte ? 2'd0 : held_count;
    nl0 = first_byte ? 3'd0 : needed_length;
    held_count_next = hc0;
    needed_length_next = nl0;
    plan.q_open = first_byte;
    if (!is_empty) begin
      if (hc0 != 2'd0) begin
        if (data_byte[7:6] != 2'b10) begin
          plan.pre_n = hc0;
          held_count_next = 2'd0;
          needed_length_next = 3'd0;
          do_start = 1'b1;
        end else if (({1'b0, hc0} + 3'd1) < nl0) begin
          wr_en = 1'b1;
          wr_idx = hc0;
          held_count_next = hc0 + 2'd1;
        end else begin
          case (nl0)
            3'd2: cp = {10'd0, held_bytes[0][4:0], data_byte[5:0]};
            3'd3: cp = {5'd0, held_bytes[0][3:0], held_bytes[1][5:0], data_byte[5:0]};
            default: cp = {held_bytes[0][2:0], held_bytes[1][5:0], held_bytes[2][5:0],
                           data_byte[5:0]};
          endcase
          held_count_next = 2'd0;
          needed_length_next = 3'd0;
          if (cp[20:16] == 5'd0) begin
            plan.kind = MK_U16;
            plan.v0 = cp[15:0];
          end else begin
            r = cp - 21'h010000;
            plan.kind = MK_PAIR;
            plan.v0 = 16'hD800 + {5'd0, r[20:10]};
            plan.v1 = {6'b110111, r[9:0]};
          end
        end
      end else begin
        do_start = 1'b1;
      end
      if (do_start) begin
        case (data_byte)
          8'h22: begin plan.kind = MK_TWO; plan.ch = CH_QUOTE; end
          8'h5C: begin plan.kind = MK_TWO; plan.ch = CH_BSL; end
          8'h08: begin plan.kind = MK_TWO; plan.ch = 7'h62; end
          8'h0C: begin plan.kind = MK_TWO; plan.ch = 7'h66; end
          8'h0A: begin plan.kind = MK_TWO; plan.ch = 7'h6E; end
          8'h0D: begin plan.kind = MK_TWO; plan.ch = 7'h72; end
          8'h09: begin plan.kind = MK_TWO; plan.ch = 7'h74; end
          default: begin
            if (data_byte < 8'h20) begin
              plan.kind = MK_U16;
              plan.v0 = {8'h00, data_byte};
            end else if (data_byte < 8'h80) begin
              plan.kind = MK_ONE;
              plan.ch = data_byte[6:0];
            end else if (data_byte[7:5] == 3'b110 || data_byte[7:4] == 4'b1110 ||
                         data_byte[7:3] == 5'b11110) begin
              wr_en = 1'b1;
              wr_idx = 2'd0;
              held_count_next = 2'd1;
              if (data_byte[7:5] == 3'b110) begin
                needed_length_next = 3'd2;
              end else if (data_byte[7:4] == 4'b1110) begin
                needed_length_next = 3'd3;
              end else begin
                needed_length_next = 3'd4;
              end
            end else begin
              plan.kind = MK_U16;
              plan.v0 = REPL_CHAR;
            end
          end
        endcase
      end
    end
    if (last_byte) begin
      plan.post_n = held_count_next;
      held_count_next = 2'd0;
      needed_length_next = 3'd0;
      plan.q_close = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= 2'd0;
      needed_length <= 3'd0;
    end else if (accept) begin
      held_count <= held_count_next;
      needed_length <= needed_length_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && wr_en) begin
      held_bytes[wr_idx] <= data_byte;
    end
  end

  a_count_fits : assert property (@(posedge clk) disable iff (rst)
    held_count != 2'd0 |-> needed_length >= 3'd2 && needed_length <= 3'd4 &&
                           {1'b0, held_count} < needed_length)
    else $error("held byte count does not fit the sequence length");

  a_idle_length : assert property (@(posedge clk) disable iff (rst)
    held_count == 2'd0 |-> needed_length == 3'd0)
    else $error("sequence length set with no held bytes");

  a_last_flushes : assert property (@(posedge clk) disable iff (rst)
    accept && last_byte |=> held_count == 2'd0)
    else $error("bytes still held after the last word of a string");

endmodule

// ===== hdl/jsesc_emit.sv =====
// Character emitter for the JSON string escaper: holds one word's plan and walks it
// out one character per cycle, unless out_ready stalls it, into the output register. Depends on jsesc_pkg.
module jsesc_emit (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_fire,
  input  jsesc_pkg::jsesc_plan_t plan_in,
  output logic                   load_ok,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [6:0]             out_char,
  output logic                   out_last
);
  import jsesc_pkg::*;

  localparam logic [2:0] SEG_NONE  = 3'd0;
  localparam logic [2:0] SEG_OPEN  = 3'd1;
  localparam logic [2:0] SEG_PRE   = 3'd2;
  localparam logic [2:0] SEG_MAIN  = 3'd3;
  localparam logic [2:0] SEG_POST  = 3'd4;
  localparam logic [2:0] SEG_CLOSE = 3'd5;

  jsesc_plan_t pl;
  jsesc_plan_t pl_next;
  logic [3:0]  sub;
  logic [3:0]  sub_next;
  logic [2:0]  seg;
  logic        busy;
  logic        emit;
  logic        unit_end;
  logic        final_char;
  logic [6:0]  ch;
  logic [3:0]  sub_hi;

  assign busy = pl.q_open || pl.pre_n != 2'd0 || pl.kind != MK_NONE ||
                pl.post_n != 2'd0 || pl.q_close;
  assign emit = busy && (!out_valid || out_ready);
  assign load_ok = !busy || (emit && final_char);
  assign sub_hi = sub - 4'd6;

  always_comb begin
    if (pl.q_open) begin
      seg = SEG_OPEN;
    end else if (pl.pre_n != 2'd0) begin
      seg = SEG_PRE;
    end else if (pl.kind != MK_NONE) begin
      seg = SEG_MAIN;
    end else if (pl.post_n != 2'd0) begin
      seg = SEG_POST;
    end else if (pl.q_close) begin
      seg = SEG_CLOSE;
    end else begin
      seg = SEG_NONE;
    end
  end

  always_comb begin
    ch = CH_QUOTE;
    unit_end = 1'b1;
    case (seg)
      SEG_PRE, SEG_POST: begin
        ch = u16_char(REPL_CHAR, sub[2:0]);
        unit_end = (sub == 4'd5);
      end
      SEG_MAIN: begin
        case (pl.kind)
          MK_ONE: ch = pl.ch;
          MK_TWO: begin
            ch = (sub == 4'd0) ? CH_BSL : pl.ch;
            unit_end = (sub == 4'd1);
          end
          MK_U16: begin
            ch = u16_char(pl.v0, sub[2:0]);
            unit_end = (sub == 4'd5);
          end
          default: begin
            ch = (sub < 4'd6) ? u16_char(pl.v0, sub[2:0]) : u16_char(pl.v1, sub_hi[2:0]);
            unit_end = (sub == 4'd11);
          end
        endcase
      end
      default: begin
        ch = CH_QUOTE;
        unit_end = 1'b1;
      end
    endcase
  end

  always_comb begin
    pl_next = pl;
    sub_next = unit_end ? 4'd0 : sub + 4'd1;
    if (unit_end) begin
      case (seg)
        SEG_OPEN:  pl_next.q_open = 1'b0;
        SEG_PRE:   pl_next.pre_n = pl.pre_n - 2'd1;
        SEG_MAIN:  pl_next.kind = MK_NONE;
        SEG_POST:  pl_next.post_n = pl.post_n - 2'd1;
        SEG_CLOSE: pl_next.q_close = 1'b0;
        default:   pl_next = pl;
      endcase
    end
    final_char = unit_end && !(pl_next.q_open || pl_next.pre_n != 2'd0 ||
                               pl_next.kind != MK_NONE || pl_next.post_n != 2'd0 ||
                               pl_next.q_close);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pl <= '0;
      sub <= 4'd0;
    end else if (in_fire) begin
      pl <= plan_in;
      sub <= 4'd0;
    end else if (emit) begin
      pl <= pl_next;
      sub <= sub_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_char <= ch;
      out_last <= final_char;
    end
  end

  a_final_marked : assert property (@(posedge clk) disable iff (rst)
    emit && final_char |=> out_valid && out_last)
    else $error("final character of a word not marked last");

  a_sub_range : assert property (@(posedge clk) disable iff (rst)
    sub <= 4'd11)
    else $error("character position out of range");

  a_stall_holds : assert property (@(posedge clk) disable iff (rst)
    busy && out_valid && !out_ready |=> $stable(sub) && $stable(pl))
    else $error("plan advanced while the output was stalled");

endmodule

// ===== hdl/json_string_ascii_escaper_top.sv =====
// Top level of the JSON string escaper: UTF-8 string bytes in, quoted ASCII JSON text out.
// Instantiates jsesc_decode and jsesc_emit; depends on jsesc_pkg.
//
// Each input word carries one string byte with first/last/empty flags and produces
// zero or more output words of one ASCII character each, the last of them flagged by
// out_last. The output side delivers one character per cycle while out_ready does not
// stall it, so a word is done once its characters are out: plain ASCII gives one, a
// two-character escape two, \uxxxx six, a surrogate pair twelve, and the worst case
// (a broken four-byte sequence at the end of a string) twenty-five characters. The
// first character goes to the output register after the word's plan is loaded into
// the emitter, and a new word is taken when the emitter is idle or in the cycle the
// previous one's final character is emitted.
module json_string_ascii_escaper_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       first_byte,
  input  logic       last_byte,
  input  logic       is_empty,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [6:0] out_char,
  output logic       out_last
);
  import jsesc_pkg::*;

  jsesc_plan_t plan;
  logic        in_fire;

  assign in_fire = in_valid && in_ready;

  jsesc_decode u_decode (
    .clk        (clk),
    .rst        (rst),
    .accept     (in_fire),
    .data_byte  (data_byte),
    .first_byte (first_byte),
    .last_byte  (last_byte),
    .is_empty   (is_empty),
    .plan       (plan)
  );

  jsesc_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (in_fire),
    .plan_in   (plan),
    .load_ok   (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_char  (out_char),
    .out_last  (out_last)
  );

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for json_string_ascii_escaper_top: directed and random strings go in,
// and every escaped character is compared with a built-in predictor of the escaper.
// Depends on jsesc_pkg and the RTL of the escaper only.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import jsesc_pkg::*;

  typedef struct packed {
    logic [6:0] ch;
    logic       last;
  } text_char_t;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] data_byte;
  logic       first_byte;
  logic       last_byte;
  logic       is_empty;
  logic       out_valid;
  logic       out_ready;
  logic [6:0] out_char;
  logic       out_last;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatch_count = 0;
  int unsigned words_sent = 0;

  text_char_t expected_text[$];
  logic [6:0] word_chars[$];
  logic [7:0] string_bytes[$];

  logic [7:0]  utf8_held[3];
  int unsigned utf8_count = 0;
  int unsigned utf8_need = 0;
  string       hex_digits = "0123456789abcdef";

  json_string_ascii_escaper_top dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .data_byte(data_byte),
    .first_byte(first_byte),
    .last_byte(last_byte),
    .is_empty(is_empty),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_char(out_char),
    .out_last(out_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("TEST FAILED");
    $finish;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin : check_output
    text_char_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_text.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected word, expected none, got char %h last %b",
                 $time, out_char, out_last);
      end else begin
        want = expected_text.pop_front();
        if (out_char !== want.ch) begin
          mismatch_count++;
          $display("%0t: out_char expected %h, got %h", $time, want.ch, out_char);
        end
        if (out_last !== want.last) begin
          mismatch_count++;
          $display("%0t: out_last expected %b, got %b", $time, want.last, out_last);
        end
      end
    end
  end

  task automatic emit_u16(input logic [15:0] v);
    logic [7:0] c;
    word_chars.push_back(CH_BSL);
    word_chars.push_back(CH_U);
    for (int i = 3; i >= 0; i--) begin
      c = hex_digits[v[i*4 +: 4]];
      word_chars.push_back(c[6:0]);
    end
  endtask

  task automatic emit_code_point(input logic [20:0] cp);
    logic [20:0] r;
    if (cp <= 21'h00FFFF) begin
      emit_u16(cp[15:0]);
    end else begin
      r = cp - 21'h010000;
      emit_u16(16'hD800 + {5'd0, r[20:10]});
      emit_u16(16'hDC00 + {6'd0, r[9:0]});
    end
  endtask

  task automatic flush_held();
    repeat (utf8_count) emit_u16(REPL_CHAR);
    utf8_count = 0;
    utf8_need = 0;
  endtask

  task automatic start_seq(input logic [7:0] b);
    int unsigned need;
    need = 0;
    case (b)
      8'h22: begin
        word_chars.push_back(CH_BSL);
        word_chars.push_back(CH_QUOTE);
      end
      8'h5C: begin
        word_chars.push_back(CH_BSL);
        word_chars.push_back(CH_BSL);
      end
      8'h08: begin
        word_chars.push_back(CH_BSL);
        word_chars.push_back(7'h62);
      end
      8'h0C: begin
        word_chars.push_back(CH_BSL);
        word_chars.push_back(7'h66);
      end
      8'h0A: begin
        word_chars.push_back(CH_BSL);
        word_chars.push_back(7'h6E);
      end
      8'h0D: begin
        word_chars.push_back(CH_BSL);
        word_chars.push_back(7'h72);
      end
      8'h09: begin
        word_chars.push_back(CH_BSL);
        word_chars.push_back(7'h74);
      end
      default: begin
        if (b < 8'h20) begin
          emit_u16({8'h00, b});
        end else if (b < 8'h80) begin
          word_chars.push_back(b[6:0]);
        end else begin
          if (b[7:5] == 3'b110) need = 2;
          else if (b[7:4] == 4'b1110) need = 3;
          else if (b[7:3] == 5'b11110) need = 4;
          if (need == 0) begin
            emit_u16(REPL_CHAR);
          end else begin
            utf8_need = need;
            utf8_held[0] = b;
            utf8_count = 1;
          end
        end
      end
    endcase
  endtask

  task automatic continue_seq(input logic [7:0] b);
    logic [20:0] cp;
    if (b[7:6] != 2'b10) begin
      flush_held();
      start_seq(b);
    end else if (utf8_count + 1 < utf8_need && utf8_count < 3) begin
      utf8_held[utf8_count] = b;
      utf8_count++;
    end else begin
      if (utf8_need == 2) begin
        cp = {10'd0, utf8_held[0][4:0], b[5:0]};
      end else if (utf8_need == 3) begin
        cp = {5'd0, utf8_held[0][3:0], utf8_held[1][5:0], b[5:0]};
      end else begin
        cp = {utf8_held[0][2:0], utf8_held[1][5:0], utf8_held[2][5:0], b[5:0]};
      end
      utf8_count = 0;
      utf8_need = 0;
      emit_code_point(cp);
    end
  endtask

  task automatic predict_word(input logic [7:0] b, input logic f, input logic l,
                              input logic e);
    text_char_t t;
    word_chars.delete();
    if (f) begin
      utf8_count = 0;
      utf8_need = 0;
      word_chars.push_back(CH_QUOTE);
    end
    if (!e) begin
      if (utf8_count > 0) continue_seq(b);
      else start_seq(b);
    end
    if (l) begin
      flush_held();
      word_chars.push_back(CH_QUOTE);
    end
    foreach (word_chars[i]) begin
      t.ch = word_chars[i];
      t.last = (i == word_chars.size() - 1);
      expected_text.push_back(t);
    end
  endtask

  task automatic send_word(input logic [7:0] b, input logic f, input logic l, input logic e);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    first_byte <= f;
    last_byte <= l;
    is_empty <= e;
    do @(posedge clk); while (!in_ready);
    predict_word(b, f, l, e);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic send_string();
    if (string_bytes.size() == 0) begin
      send_word(8'h00, 1'b1, 1'b1, 1'b1);
    end else begin
      foreach (string_bytes[i]) begin
        send_word(string_bytes[i], i == 0, i == string_bytes.size() - 1, 1'b0);
      end
    end
  endtask

  task automatic add_utf8_lead(input int unsigned n, input logic [20:0] cp);
    if (n == 2) string_bytes.push_back({3'b110, cp[4:0]});
    else if (n == 3) string_bytes.push_back({4'b1110, cp[3:0]});
    else string_bytes.push_back({5'b11110, cp[2:0]});
  endtask

  task automatic add_random_char();
    int unsigned kind;
    int unsigned n;
    logic [20:0] cp;
    kind = $urandom_range(0, 99);
    cp = 21'($urandom);
    if (kind < 35) begin
      string_bytes.push_back(8'($urandom_range(8'h20, 8'h7F)));
    end else if (kind < 50) begin
      if ($urandom_range(0, 2) == 0) string_bytes.push_back($urandom_range(0, 1) ? 8'h22 : 8'h5C);
      else string_bytes.push_back(8'($urandom_range(0, 31)));
    end else if (kind < 65) begin
      string_bytes.push_back({3'b110, cp[10:6]});
      string_bytes.push_back({2'b10, cp[5:0]});
    end else if (kind < 78) begin
      string_bytes.push_back({4'b1110, cp[15:12]});
      string_bytes.push_back({2'b10, cp[11:6]});
      string_bytes.push_back({2'b10, cp[5:0]});
    end else if (kind < 90) begin
      string_bytes.push_back({5'b11110, cp[20:18]});
      string_bytes.push_back({2'b10, cp[17:12]});
      string_bytes.push_back({2'b10, cp[11:6]});
      string_bytes.push_back({2'b10, cp[5:0]});
    end else if (kind < 95) begin
      n = $urandom_range(2, 4);
      add_utf8_lead(n, cp);
      repeat ($urandom_range(0, n - 2)) string_bytes.push_back({2'b10, 6'($urandom)});
    end else begin
      if ($urandom_range(0, 1)) string_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
      else string_bytes.push_back(8'($urandom_range(8'hF8, 8'hFF)));
    end
  endtask

  task automatic test_empty_string();
    send_word(8'h00, 1'b1, 1'b1, 1'b1);
  endtask

  task automatic test_ascii_escapes();
    string_bytes = '{8'h00, 8'h08, 8'h09, 8'h0A, 8'h0C, 8'h0D, 8'h1F, 8'h20, 8'h22, 8'h5C, 8'h7F};
    send_string();
  endtask

  task automatic test_utf8_sequences();
    string_bytes = '{8'hC0, 8'h80, 8'hED, 8'hA0, 8'h80, 8'hF7, 8'hBF, 8'hBF, 8'hBF};
    send_string();
  endtask

  task automatic test_malformed_input();
    send_word(8'hE2, 1'b1, 1'b0, 1'b0);
    send_word(8'h41, 1'b0, 1'b0, 1'b0);
    send_word(8'hFF, 1'b0, 1'b0, 1'b0);
    send_word(8'hF0, 1'b0, 1'b0, 1'b0);
    send_word(8'h90, 1'b0, 1'b1, 1'b0);
    send_word(8'hF0, 1'b0, 1'b0, 1'b0);
    send_word(8'hA5, 1'b1, 1'b0, 1'b1);
    send_word(8'hC3, 1'b0, 1'b0, 1'b0);
    send_word(8'h5A, 1'b0, 1'b0, 1'b1);
    send_word(8'h00, 1'b0, 1'b1, 1'b1);
  endtask

  task automatic test_random_strings(input int unsigned n_words, input int unsigned idle_pct,
                                     input int unsigned stall_pct);
    int unsigned target;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    target = words_sent + n_words;
    while (words_sent < target) begin
      if ($urandom_range(0, 99) < 12) begin
        send_word(8'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
      end else begin
        string_bytes.delete();
        repeat ($urandom_range(0, 6)) add_random_char();
        send_string();
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    data_byte = 8'h00;
    first_byte = 1'b0;
    last_byte = 1'b0;
    is_empty = 1'b0;
    out_ready = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_empty_string();
    test_ascii_escapes();
    test_utf8_sequences();
    test_malformed_input();
    test_random_strings(35, 0, 0);
    test_random_strings(30, 88, 0);
    test_random_strings(30, 0, 88);
    test_random_strings(35, 7, 7);

    in_valid <= 1'b0;
    while (expected_text.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && expected_text.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
